[hdl/qrsg_pkg.sv]
// Shared types and constants of the quasi-random sample generator.
`default_nettype none
package qrsg_pkg;

  localparam int unsigned DVD_W   = 64;  // dividend width of the divider
  localparam int unsigned DVS_W   = 32;  // divisor, quotient and remainder width
  localparam int unsigned ITER_W  = 7;   // iteration count width
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned IDX_W   = 31;
  localparam int unsigned RAD_W   = 8;

  localparam logic [ITER_W-1:0] HAM_ITERS = 7'd64;
  localparam logic [ITER_W-1:0] DIG_ITERS = 7'd31;
  localparam logic [ITER_W-1:0] ACC_ITERS = 7'd40;

  localparam logic [1:0] OP_HAMMERSLEY = 2'd0;
  localparam logic [1:0] OP_HALTON     = 2'd1;
  localparam logic [1:0] OP_SOBOL      = 2'd2;
  localparam logic [1:0] OP_LP         = 2'd3;

  localparam logic [COORD_W-1:0] SOBOL_V1_INIT = 32'h8000_0000;
  localparam logic [COORD_W-1:0] SOBOL_V2_INIT = 32'hC000_0000;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVS_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

[hdl/qrsg_div.sv]
// Restoring divider, one quotient bit per cycle, dividend taken MSB first.
`default_nettype none
module qrsg_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire qrsg_pkg::div_req_t req_i,
  output qrsg_pkg::div_rsp_t      rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [qrsg_pkg::ITER_W-1:0]   cnt_q, cnt_d;
  logic [qrsg_pkg::DVD_W-1:0]    dvd_q, dvd_d;
  logic [qrsg_pkg::DVS_W-1:0]    dvs_q, dvs_d;
  logic [qrsg_pkg::DVS_W-1:0]    rem_q, rem_d;
  logic [qrsg_pkg::DVS_W-1:0]    quo_q, quo_d;
  logic [qrsg_pkg::DVS_W:0]      trial;
  logic                          fits;

  assign trial = {rem_q, dvd_q[qrsg_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      // Subtract when the divisor fits, shift the next dividend bit in.
      rem_d = fits ? qrsg_pkg::DVS_W'(trial - {1'b0, dvs_q})
                   : trial[qrsg_pkg::DVS_W-1:0];
      quo_d = {quo_q[qrsg_pkg::DVS_W-2:0], fits};
      dvd_d = {dvd_q[qrsg_pkg::DVD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == qrsg_pkg::ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with zero count");
`endif

endmodule
`default_nettype wire

[hdl/quasi_random_sample_generator.sv]
// Top level of the quasi-random sample generator: sequencer, digit store, register.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------------------
//   in       | input     | in_valid_i / in_stall_o   | opcode, index, radix, scramble
//   out      | output    | out_valid_o / out_stall_i | first_coord, second_coord, status
//   config   | input     | APB psel/penable/pready   | set_size at byte address 0
//
// Hammersley makes one 64-bit pass of the shared bit-serial divider.
// Halton peels each of the D base-radix digits of the index with a divider pass of 31
// steps, then folds each digit back with a divider pass of 40 steps.
// Sobol and scrambled modes take one significant index bit per cycle.
// Reset clears the sequencer and sets set_size to 1. An item is taken only while the
// sequencer is idle; a finished result waits in the output register while the next
// transfer is accepted, and the sequencer holds at its end if that register is still full.
`default_nettype none
module quasi_random_sample_generator #(
  parameter int unsigned INDEX_BITS = 31,
  parameter int unsigned RADIX_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [30:0] index_i,
  input  wire logic [7:0]  radix_i,
  input  wire logic [31:0] scramble_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      first_coord_o,
  output logic [31:0]      second_coord_o,
  output logic             status_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CNT_W = $clog2(INDEX_BITS + 1);
  localparam int unsigned DA_W  = $clog2(INDEX_BITS);
  localparam logic [qrsg_pkg::IDX_W-1:0] IDX_MASK =
    qrsg_pkg::IDX_W'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [qrsg_pkg::RAD_W-1:0] RAD_MASK =
    qrsg_pkg::RAD_W'((64'd1 << RADIX_BITS) - 64'd1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HAM  = 3'd1;
  localparam logic [2:0] S_DIG  = 3'd2;
  localparam logic [2:0] S_DIGW = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_ACCW = 3'd5;
  localparam logic [2:0] S_SOB  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]                     state_q, state_d;
  logic [qrsg_pkg::SIZE_W-1:0]    set_size_q;
  logic [1:0]                     op_q, op_d;
  logic [qrsg_pkg::IDX_W-1:0]     work_q, work_d;
  logic [qrsg_pkg::RAD_W-1:0]     base_q, base_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [CNT_W-1:0]               cnt_m1;
  logic [qrsg_pkg::COORD_W-1:0]   r1_q, r1_d, r2_q, r2_d, v1_q, v1_d, v2_q, v2_d;
  logic                           bad_q, bad_d;
  logic [qrsg_pkg::RAD_W-1:0]     digits_q [INDEX_BITS];
  logic                           dig_we;
  logic [CNT_W-1:0]               dig_ra;
  logic [qrsg_pkg::RAD_W-1:0]     dig_rd_q;

  logic                           out_valid_q, out_valid_d;
  logic [qrsg_pkg::COORD_W-1:0]   c1_q, c2_q;
  logic                           st_q;
  logic                           out_load;

  logic                           accept;
  logic [qrsg_pkg::IDX_W-1:0]     idx_m;
  logic [qrsg_pkg::RAD_W-1:0]     rad_m;
  logic                           ham_bad;

  qrsg_pkg::div_req_t             div_req;
  qrsg_pkg::div_rsp_t             div_rsp;

  qrsg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_m      = index_i & IDX_MASK;
  assign rad_m      = radix_i & RAD_MASK;
  assign ham_bad    = (set_size_q == '0) || (idx_m >= set_size_q);
  assign cnt_m1     = cnt_q - 1'b1;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  // read the digit just below the next count, so it is ready in S_ACC
  assign dig_ra     = cnt_d - 1'b1;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    work_d  = work_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    v1_d    = v1_q;
    v2_d    = v2_q;
    bad_d   = bad_q;
    dig_we  = 1'b0;
    div_req = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = opcode_i;
          work_d = idx_m;
          base_d = rad_m;
          cnt_d  = '0;
          r1_d   = '0;
          r2_d   = '0;
          v1_d   = qrsg_pkg::SOBOL_V1_INIT;
          v2_d   = qrsg_pkg::SOBOL_V2_INIT;
          bad_d  = 1'b0;
          case (opcode_i)
            qrsg_pkg::OP_HAMMERSLEY: begin
              if (ham_bad) begin
                bad_d   = 1'b1;
                state_d = S_FIN;
              end else begin
                // (2*index + 1) * 2^31 over set_size
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, idx_m, 1'b1, 31'd0};
                div_req.divisor  = {1'b0, set_size_q};
                div_req.iters    = qrsg_pkg::HAM_ITERS;
                state_d          = S_HAM;
              end
            end
            qrsg_pkg::OP_HALTON: begin
              if (rad_m < qrsg_pkg::RAD_W'(2)) begin
                bad_d   = 1'b1;
                state_d = S_FIN;
              end else begin
                state_d = S_DIG;
              end
            end
            qrsg_pkg::OP_SOBOL: state_d = S_SOB;
            default: begin
              r1_d    = scramble_i;
              state_d = S_SOB;
            end
          endcase
        end
      end
      S_HAM: begin
        if (div_rsp.done) begin
          r1_d    = div_rsp.quot;
          state_d = S_FIN;
        end
      end
      S_DIG: begin
        // Peel the least significant digit, or switch to folding when done.
        if (work_q == '0 || cnt_q == CNT_W'(INDEX_BITS)) begin
          r1_d    = '0;
          state_d = S_ACC;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {work_q, 33'd0};
          div_req.divisor  = {24'd0, base_q};
          div_req.iters    = qrsg_pkg::DIG_ITERS;
          state_d          = S_DIGW;
        end
      end
      S_DIGW: begin
        if (div_rsp.done) begin
          dig_we  = 1'b1;
          work_d  = div_rsp.quot[qrsg_pkg::IDX_W-1:0];
          cnt_d   = cnt_q + 1'b1;
          state_d = S_DIG;
        end
      end
      S_ACC: begin
        // Fold digits back from the most significant: acc = (d*2^32 + acc) / radix.
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {dig_rd_q, r1_q, 24'd0};
          div_req.divisor  = {24'd0, base_q};
          div_req.iters    = qrsg_pkg::ACC_ITERS;
          cnt_d            = cnt_m1;
          state_d          = S_ACCW;
        end
      end
      S_ACCW: begin
        if (div_rsp.done) begin
          r1_d    = div_rsp.quot;
          state_d = S_ACC;
        end
      end
      S_SOB: begin
        // One index bit per cycle; stop once no set bit remains.
        if (work_q == '0) begin
          state_d = S_FIN;
        end else begin
          if (work_q[0]) begin
            r1_d = r1_q ^ v1_q;
            r2_d = r2_q ^ {v2_q[qrsg_pkg::COORD_W-2:0], 1'b0};
          end
          v1_d   = v1_q | (v1_q >> 1);
          v2_d   = v2_q ^ (v2_q >> 1);
          work_d = work_q >> 1;
        end
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    work_q  <= work_d;
    base_q  <= base_d;
    cnt_q   <= cnt_d;
    r1_q    <= r1_d;
    r2_q    <= r2_d;
    v1_q    <= v1_d;
    v2_q    <= v2_d;
    bad_q   <= bad_d;
  end

  // digit store, written by the peel loop, read back registered by the fold loop
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[cnt_q[DA_W-1:0]] <= div_rsp.rem[qrsg_pkg::RAD_W-1:0];
    end
    dig_rd_q <= digits_q[dig_ra[DA_W-1:0]];
  end

  // output register: hold until the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      c1_q <= r1_q;
      c2_q <= (op_q == qrsg_pkg::OP_SOBOL) ? r2_q : '0;
      st_q <= bad_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_coord_o  = c1_q;
  assign second_coord_o = c2_q;
  assign status_o       = st_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q <= qrsg_pkg::SIZE_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
      set_size_q <= pwdata[qrsg_pkg::SIZE_W-1:0];
    end
  end

  assign prdata = (paddr == 3'd0) ? {1'b0, set_size_q} : '0;
  assign pready = 1'b1;

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> first_coord_o == '0 && second_coord_o == '0)
    else $error("bad argument with nonzero coordinate");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(INDEX_BITS) || state_q == S_IDLE || state_q == S_SOB
      || state_q == S_HAM || state_q == S_FIN)
    else $error("digit count beyond store depth");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_HAM || state_q == S_DIGW || state_q == S_ACCW)
    else $error("divider result outside a wait state");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_valid_q && out_stall_i |=> state_q == S_FIN)
    else $error("result dropped while output register full");
`endif

endmodule
`default_nettype wire
